// ----- rtl/core/dale_pkg.sv -----
// shared types, constants and helpers for the decimal ascii line encoder
package dale_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned MULT_W  = 17;
    localparam int unsigned RADIX   = 10;

    // digit place: 0 is ten-thousands ... 4 is ones, 5 is the closing newline
    typedef logic [2:0] place_t;

    localparam place_t PLACE_TEN_THOUSANDS = 3'd0;
    localparam place_t PLACE_THOUSANDS     = 3'd1;
    localparam place_t PLACE_HUNDREDS      = 3'd2;
    localparam place_t PLACE_TENS          = 3'd3;
    localparam place_t PLACE_ONES          = 3'd4;
    localparam place_t PLACE_NEWLINE       = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;

    localparam logic [VALUE_W-1:0] TEN_THOUSAND = 16'd10000;
    localparam logic [VALUE_W-1:0] THOUSAND     = 16'd1000;
    localparam logic [VALUE_W-1:0] HUNDRED      = 16'd100;
    localparam logic [VALUE_W-1:0] TEN          = 16'd10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        place_t             place;
    } item_t;

    // weight of one digit at a given place
    function automatic logic [MULT_W-1:0] place_unit(place_t place);
        logic [MULT_W-1:0] unit;
        case (place)
            PLACE_TEN_THOUSANDS: unit = 17'd10000;
            PLACE_THOUSANDS:     unit = 17'd1000;
            PLACE_HUNDREDS:      unit = 17'd100;
            PLACE_TENS:          unit = 17'd10;
            default:             unit = 17'd1;
        endcase
        return unit;
    endfunction

endpackage

// ----- rtl/core/dale_ifs.sv -----
// valid/ready channel interfaces for sample input and character output
interface dale_in_if import dale_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
    modport monitor (input valid, input sample_value, input ready);
endinterface

interface dale_out_if import dale_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic              is_last;

    modport source (output valid, output ascii_char, output is_last, input ready);
    modport sink (input valid, input ascii_char, input is_last, output ready);
    modport monitor (input valid, input ascii_char, input is_last, input ready);
endinterface

// ----- rtl/core/dale_front.sv -----
// front stage: takes samples and finds the leading decimal place
module dale_front import dale_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dale_in_if.sink       samples,
    output logic          wr_valid,
    input  logic          wr_ready,
    output item_t         wr_data
);

    logic   valid_reg;
    logic   valid_next;
    item_t  item_reg;
    place_t lead_place;
    logic   take;

    always_comb
    begin
        if (samples.sample_value >= TEN_THOUSAND)
        begin
            lead_place = PLACE_TEN_THOUSANDS;
        end
        else if (samples.sample_value >= THOUSAND)
        begin
            lead_place = PLACE_THOUSANDS;
        end
        else if (samples.sample_value >= HUNDRED)
        begin
            lead_place = PLACE_HUNDREDS;
        end
        else if (samples.sample_value >= TEN)
        begin
            lead_place = PLACE_TENS;
        end
        else
        begin
            lead_place = PLACE_ONES;
        end
    end

    assign samples.ready = !valid_reg || wr_ready;
    assign take          = samples.valid && samples.ready;
    assign valid_next    = take || (valid_reg && !wr_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{value: samples.sample_value, place: lead_place};
        end
    end

    assign wr_valid = valid_reg;
    assign wr_data  = item_reg;

endmodule

// ----- rtl/core/dale_queue.sv -----
// two-entry fifo between the front and back stages
module dale_queue import dale_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_data
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/dale_back.sv -----
// back stage: drives the character channel, one decimal digit per cycle while not stalled
module dale_back import dale_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rd_valid,
    output logic      rd_ready,
    input  item_t     rd_data,
    dale_out_if.source chars
);

    logic               busy_reg;
    logic               busy_next;
    place_t             place_reg;
    place_t             place_next;
    logic [VALUE_W-1:0] rest_reg;
    logic [VALUE_W-1:0] rest_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [MULT_W-1:0]  unit;
    logic [MULT_W-1:0]  mult [RADIX];
    logic [DIGIT_W-1:0] digit;
    logic [MULT_W-1:0]  sub;
    logic [VALUE_W-1:0] rest_after;
    logic               at_newline;
    logic               adv;
    logic               emit;
    logic               load;

    // digit by comparing against each multiple, one to nine, of the place weight
    always_comb
    begin
        unit  = place_unit(place_reg);
        digit = '0;
        sub   = '0;
        for (int k = 0; k < RADIX; k++)
        begin
            mult[k] = MULT_W'(unit * MULT_W'(k));
        end
        for (int k = 1; k < RADIX; k++)
        begin
            if ({1'b0, rest_reg} >= mult[k])
            begin
                digit = DIGIT_W'(k);
            end
        end
        for (int k = 0; k < RADIX; k++)
        begin
            if (digit == DIGIT_W'(k))
            begin
                sub = mult[k];
            end
        end
        rest_after = VALUE_W'({1'b0, rest_reg} - sub);
    end

    assign at_newline = (place_reg == PLACE_NEWLINE);
    assign adv        = !out_valid_reg || chars.ready;
    assign emit       = adv && busy_reg;
    // next value loads in the same cycle its predecessor's newline is emitted into the output register
    assign load       = adv && (!busy_reg || at_newline) && rd_valid;
    assign rd_ready   = adv && (!busy_reg || at_newline);

    always_comb
    begin
        busy_next      = busy_reg;
        place_next     = place_reg;
        rest_next      = rest_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = busy_reg;
        end
        if (load)
        begin
            busy_next  = 1'b1;
            place_next = rd_data.place;
            rest_next  = rd_data.value;
        end
        else if (emit)
        begin
            if (at_newline)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                place_next = place_reg + 3'd1;
                rest_next  = rest_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            place_reg     <= PLACE_NEWLINE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            place_reg     <= place_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        if (emit)
        begin
            char_reg <= at_newline ? CHAR_NEWLINE : CHAR_ZERO + CHAR_W'(digit);
            last_reg <= at_newline;
        end
    end

    assign chars.valid      = out_valid_reg;
    assign chars.ascii_char = char_reg;
    assign chars.is_last    = last_reg;

endmodule

// ----- rtl/core/decimal_ascii_line_encoder_top.sv -----
// top level of the decimal ascii line encoder
//
// samples: valid/ready channel, one unsigned 16-bit value per transfer.
// chars:   valid/ready channel, one 7-bit ascii character per transfer.
//          a value is printed in decimal, most significant digit first,
//          leading zeros dropped (zero prints as a single '0'), and its line
//          ends with a newline that carries is_last.
// throughput: one character per cycle while chars.ready is high; the back
//          stage's digit unit emits one place per cycle. back-to-back values
//          keep the chars channel busy every cycle.
// path:    a sample passes the front register, the queue, the back stage's
//          place and value registers and the output register in turn.
// reset:   rst_n asynchronous, active low; all items in flight are dropped
//          and both channels come up empty.
// stall:   when chars.ready is low the current character holds; the queue
//          and front register absorb up to three more samples before
//          samples.ready drops.
module decimal_ascii_line_encoder_top import dale_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dale_in_if.sink     samples,
    dale_out_if.source  chars
);

    logic  wr_valid;
    logic  wr_ready;
    item_t wr_data;
    logic  rd_valid;
    logic  rd_ready;
    item_t rd_data;

    dale_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data)
    );

    dale_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data)
    );

    dale_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data),
        .chars    (chars)
    );

endmodule

// ----- rtl/core/dale_checker.sv -----
// port-level checks on the character stream, bound to the top level
module dale_checker import dale_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              chars_valid,
    input logic              chars_ready,
    input logic [CHAR_W-1:0] ascii_char,
    input logic              is_last
);

    logic       line_start_reg;
    logic [2:0] digit_cnt_reg;
    logic       xfer;

    assign xfer = chars_valid && chars_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
            digit_cnt_reg  <= 3'd0;
        end
        else if (xfer)
        begin
            line_start_reg <= is_last;
            digit_cnt_reg  <= is_last ? 3'd0 : digit_cnt_reg + 3'd1;
        end
    end

    // stalled character holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chars_valid && !chars_ready |=>
            chars_valid && $stable(ascii_char) && $stable(is_last))
        else $error("character changed while stalled");

    // digits carry no last flag, the newline always does
    a_format: assert property (@(posedge clk) disable iff (!rst_n)
        chars_valid |->
            (is_last && ascii_char == CHAR_NEWLINE) ||
            (!is_last && ascii_char >= CHAR_ZERO && ascii_char <= CHAR_NINE))
        else $error("bad character or last flag");

    // every line has at least one digit
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && is_last |-> !line_start_reg)
        else $error("newline with no digits");

    // no more than five digits per line
    a_max_digits: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !is_last |-> digit_cnt_reg < 3'd5)
        else $error("more than five digits in a line");

endmodule

bind decimal_ascii_line_encoder_top dale_checker u_dale_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .chars_valid (chars.valid),
    .chars_ready (chars.ready),
    .ascii_char  (chars.ascii_char),
    .is_last     (chars.is_last)
);
